@@ rtl/core/fwc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwc_pkg
// Shared constants and controller/datapath interface types for the
// flow weighted centroid block.
// ----------------------------------------------------------------------------
package fwc_pkg;

	localparam int MAX_WIDTH  = 128;
	localparam int MAX_HEIGHT = 64;
	localparam int FLOW_BITS  = 16;

	localparam int COL_BITS   = $clog2(MAX_WIDTH);
	localparam int ROW_BITS   = $clog2(MAX_HEIGHT);
	localparam int ADDR_BITS  = COL_BITS + ROW_BITS;
	localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;

	localparam int MSUM_BITS  = 29;
	localparam int CSUM_BITS  = 36;
	localparam int RSUM_BITS  = 35;
	localparam int CNT_BITS   = 14;
	localparam int DVD_BITS   = CSUM_BITS + 8;
	localparam int SQ_BITS    = 2 * FLOW_BITS;
	localparam int MAG_BITS   = FLOW_BITS;

	localparam logic [1:0] REG_WIDTH   = 2'd0;
	localparam logic [1:0] REG_HEIGHT  = 2'd1;
	localparam logic [1:0] REG_THRESH  = 2'd2;
	localparam logic [1:0] REG_PERMILL = 2'd3;

	typedef struct packed {
		logic accept;
		logic sq_en;
		logic sq_sel;
		logic root_start;
		logic acc;
		logic div_start;
		logic div_sel;
		logic latch_cx;
		logic latch_cy;
		logic mem_rd;
		logic out_latch;
		logic out_zero;
	} cmd_t;

	typedef struct packed {
		logic last;
		logic sum_zero;
		logic root_done;
		logic div_done;
	} status_t;

endpackage

@@ rtl/core/fwc_sqrt.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwc_sqrt
// Bit-serial integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module fwc_sqrt import fwc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [SQ_BITS-1:0]  operand,
	output logic [MAG_BITS-1:0] root,
	output logic                done
);

	logic [SQ_BITS-1:0] v_q;
	logic [SQ_BITS-1:0] r_q;
	logic [SQ_BITS-1:0] bit_q;
	logic [$clog2(MAG_BITS+1)-1:0] cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [SQ_BITS:0]   trial;

	assign trial = {1'b0, r_q} + {1'b0, bit_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= ($clog2(MAG_BITS+1))'(MAG_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == 1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= operand;
			r_q   <= '0;
			bit_q <= {2'b01, {(SQ_BITS-2){1'b0}}};
		end else if (busy_q) begin
			if ({1'b0, v_q} >= trial) begin
				v_q <= v_q - trial[SQ_BITS-1:0];
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign root = r_q[MAG_BITS-1:0];
	assign done = done_q;

endmodule

@@ rtl/core/fwc_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwc_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fwc_div import fwc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [DVD_BITS-1:0]  dividend,
	input  logic [MSUM_BITS-1:0] divisor,
	output logic [DVD_BITS-1:0]  quotient,
	output logic                 done
);

	logic [DVD_BITS-1:0]  dvd_q;
	logic [MSUM_BITS-1:0] dvs_q;
	logic [MSUM_BITS:0]   rem_q;
	logic [MSUM_BITS:0]   rem_sh;
	logic                 ge;
	logic [$clog2(DVD_BITS+1)-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;

	assign rem_sh = {rem_q[MSUM_BITS-1:0], dvd_q[DVD_BITS-1]};
	assign ge     = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= ($clog2(DVD_BITS+1))'(DVD_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == 1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
			dvd_q <= {dvd_q[DVD_BITS-2:0], ge};
		end
	end

	assign quotient = dvd_q;
	assign done     = done_q;

endmodule

@@ rtl/core/fwc_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwc_datapath
// Configuration registers, flow store, accumulators, square root and
// divider units and result registers.
// ----------------------------------------------------------------------------
module fwc_datapath import fwc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_index,
	input  logic [15:0]           cfg_wdata,
	input  logic signed [15:0]    flow_x,
	input  logic signed [15:0]    flow_y,
	input  cmd_t                  cmd,
	output status_t               status,
	output logic [14:0]           center_x,
	output logic [13:0]           center_y,
	output logic [15:0]           center_magnitude,
	output logic [13:0]           moving_pixels,
	output logic                  flow_valid
);

	logic [7:0]  frame_width_q;
	logic [6:0]  frame_height_q;
	logic [15:0] min_flow_threshold_q;
	logic [9:0]  max_moving_permille_q;

	logic [7:0]  w_eff;
	logic [6:0]  h_eff;

	logic [COL_BITS-1:0] col_q, pix_col_q;
	logic [ROW_BITS-1:0] row_q, pix_row_q;
	logic                last_q;
	logic [13:0]         pixels_q;

	logic [SQ_BITS-1:0]  mem [0:STORE_DEPTH-1];
	logic [SQ_BITS-1:0]  rd_q;

	logic [FLOW_BITS-1:0] x_q, y_q;
	logic [FLOW_BITS-1:0] sx, sy;
	logic [SQ_BITS-1:0]   px, py;
	logic [SQ_BITS-2:0]   sqx_q, sqy_q;
	logic [SQ_BITS-1:0]   sq_sum;
	logic [MAG_BITS-1:0]  mag;
	logic                 root_done;
	logic                 div_done;

	logic [MSUM_BITS-1:0] msum_q;
	logic [CSUM_BITS-1:0] csum_q;
	logic [RSUM_BITS-1:0] rsum_q;
	logic [CNT_BITS-1:0]  cnt_q;
	logic [MSUM_BITS:0]   msum_n;
	logic [CSUM_BITS:0]   csum_n;
	logic [RSUM_BITS:0]   rsum_n;

	logic [DVD_BITS-1:0]  dividend;
	logic [DVD_BITS-1:0]  quotient;
	logic [14:0]          cx_q;
	logic [13:0]          cy_q;
	logic [23:0]          moving_scaled;
	logic [23:0]          limit_scaled;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q         <= 8'd80;
			frame_height_q        <= 7'd60;
			min_flow_threshold_q  <= 16'd256;
			max_moving_permille_q <= 10'd100;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WIDTH:   frame_width_q         <= cfg_wdata[7:0];
				REG_HEIGHT:  frame_height_q        <= cfg_wdata[6:0];
				REG_THRESH:  min_flow_threshold_q  <= cfg_wdata;
				REG_PERMILL: max_moving_permille_q <= cfg_wdata[9:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (frame_width_q == 8'd0)
			w_eff = 8'd1;
		else if (frame_width_q > 8'(MAX_WIDTH))
			w_eff = 8'(MAX_WIDTH);
		else
			w_eff = frame_width_q;
		if (frame_height_q == 7'd0)
			h_eff = 7'd1;
		else if (frame_height_q > 7'(MAX_HEIGHT))
			h_eff = 7'(MAX_HEIGHT);
		else
			h_eff = frame_height_q;
	end

	// raster position and end of frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			last_q <= 1'b0;
		end else if (cmd.accept) begin
			last_q <= 1'b0;
			if ({1'b0, col_q} >= w_eff - 8'd1) begin
				col_q <= '0;
				if ({1'b0, row_q} >= h_eff - 7'd1)
					last_q <= 1'b1;
				else
					row_q <= row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end else if (cmd.out_latch) begin
			col_q  <= '0;
			row_q  <= '0;
			last_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			x_q       <= flow_x;
			y_q       <= flow_y;
			pix_col_q <= col_q;
			pix_row_q <= row_q;
			pixels_q  <= 14'(w_eff * h_eff);
			mem[{row_q, col_q}] <= {flow_y, flow_x};
		end
		if (cmd.mem_rd)
			rd_q <= mem[{cy_q[13:8], cx_q[14:8]}];
	end

	assign sx = cmd.sq_sel ? rd_q[FLOW_BITS-1:0] : x_q;
	assign sy = cmd.sq_sel ? rd_q[SQ_BITS-1:FLOW_BITS] : y_q;
	assign px = $signed(sx) * $signed(sx);
	assign py = $signed(sy) * $signed(sy);

	always_ff @(posedge clk) begin
		if (cmd.sq_en) begin
			sqx_q <= px[SQ_BITS-2:0];
			sqy_q <= py[SQ_BITS-2:0];
		end
	end

	assign sq_sum = {1'b0, sqx_q} + {1'b0, sqy_q};

	fwc_sqrt u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.root_start),
		.operand (sq_sum),
		.root    (mag),
		.done    (root_done)
	);

	assign msum_n = {1'b0, msum_q} + (MSUM_BITS+1)'(mag);
	assign csum_n = {1'b0, csum_q} + (CSUM_BITS+1)'(mag * pix_col_q);
	assign rsum_n = {1'b0, rsum_q} + (RSUM_BITS+1)'(mag * pix_row_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msum_q <= '0;
			csum_q <= '0;
			rsum_q <= '0;
			cnt_q  <= '0;
		end else if (cmd.acc) begin
			msum_q <= msum_n[MSUM_BITS] ? '1 : msum_n[MSUM_BITS-1:0];
			csum_q <= csum_n[CSUM_BITS] ? '1 : csum_n[CSUM_BITS-1:0];
			rsum_q <= rsum_n[RSUM_BITS] ? '1 : rsum_n[RSUM_BITS-1:0];
			if (mag > min_flow_threshold_q && cnt_q != '1)
				cnt_q <= cnt_q + 1'b1;
		end else if (cmd.out_latch) begin
			msum_q <= '0;
			csum_q <= '0;
			rsum_q <= '0;
			cnt_q  <= '0;
		end
	end

	assign dividend = cmd.div_sel ? {1'b0, rsum_q, 8'd0} : {csum_q, 8'd0};

	fwc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dividend),
		.divisor  (msum_q),
		.quotient (quotient),
		.done     (div_done)
	);

	always_ff @(posedge clk) begin
		if (cmd.latch_cx)
			cx_q <= (quotient > DVD_BITS'(32767)) ? 15'h7fff : quotient[14:0];
		if (cmd.latch_cy)
			cy_q <= (quotient > DVD_BITS'(16383)) ? 14'h3fff : quotient[13:0];
	end

	assign moving_scaled = 24'(cnt_q * 10'd1000);
	assign limit_scaled  = 24'(max_moving_permille_q * pixels_q);

	always_ff @(posedge clk) begin
		if (cmd.out_latch) begin
			center_x         <= cmd.out_zero ? '0 : cx_q;
			center_y         <= cmd.out_zero ? '0 : cy_q;
			center_magnitude <= cmd.out_zero ? '0 : mag;
			moving_pixels    <= cnt_q;
			flow_valid       <= !cmd.out_zero && (mag > min_flow_threshold_q)
				&& (moving_scaled < limit_scaled);
		end
	end

	// field order: last, sum_zero, root_done, div_done
	assign status = {last_q, (msum_q == '0), root_done, div_done};

endmodule

@@ rtl/core/fwc_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwc_ctrl
// Sequencer for per-pixel accumulation and end-of-frame centroid.
// ----------------------------------------------------------------------------
module fwc_ctrl import fwc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  status_t status,
	output cmd_t    cmd,
	output logic    busy,
	output logic    done
);

	typedef enum logic [9:0] {
		ST_IDLE = 10'b0000000001,
		ST_SQ   = 10'b0000000010,
		ST_RS   = 10'b0000000100,
		ST_RW   = 10'b0000001000,
		ST_ACC  = 10'b0000010000,
		ST_FIN  = 10'b0000100000,
		ST_DX   = 10'b0001000000,
		ST_DY   = 10'b0010000000,
		ST_RD   = 10'b0100000000,
		ST_OUT  = 10'b1000000000
	} state_t;

	state_t state_q, state_n;
	logic   center_q, center_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			center_q <= 1'b0;
		end else begin
			state_q  <= state_n;
			center_q <= center_n;
		end
	end

	always_comb begin
		state_n  = state_q;
		center_n = center_q;
		cmd      = '0;
		cmd.sq_sel = center_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.accept = 1'b1;
					center_n   = 1'b0;
					state_n    = ST_SQ;
				end
			end
			ST_SQ: begin
				cmd.sq_en = 1'b1;
				state_n   = ST_RS;
			end
			ST_RS: begin
				cmd.root_start = 1'b1;
				state_n        = ST_RW;
			end
			ST_RW: begin
				if (status.root_done) begin
					if (center_q) begin
						cmd.out_latch = 1'b1;
						state_n       = ST_OUT;
					end else begin
						state_n = ST_ACC;
					end
				end
			end
			ST_ACC: begin
				cmd.acc = 1'b1;
				state_n = status.last ? ST_FIN : ST_IDLE;
			end
			ST_FIN: begin
				if (status.sum_zero) begin
					cmd.out_latch = 1'b1;
					cmd.out_zero  = 1'b1;
					state_n       = ST_OUT;
				end else begin
					cmd.div_start = 1'b1;
					state_n       = ST_DX;
				end
			end
			ST_DX: begin
				if (status.div_done) begin
					cmd.latch_cx  = 1'b1;
					cmd.div_start = 1'b1;
					cmd.div_sel   = 1'b1;
					state_n       = ST_DY;
				end
			end
			ST_DY: begin
				cmd.div_sel = 1'b1;
				if (status.div_done) begin
					cmd.latch_cy = 1'b1;
					state_n      = ST_RD;
				end
			end
			ST_RD: begin
				cmd.mem_rd = 1'b1;
				center_n   = 1'b1;
				state_n    = ST_SQ;
			end
			ST_OUT: begin
				state_n = ST_IDLE;
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_OUT);

	// result strobe lasts exactly one cycle
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe held");

	// an accepted pixel always makes the block busy next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accept without busy");

	// the divider is only started with a nonzero magnitude sum
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !status.sum_zero) else $error("divide by zero sum");

endmodule

@@ rtl/core/flow_weighted_centroid.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flow_weighted_centroid
// Magnitude-weighted centroid of a raster optical-flow frame.
// ----------------------------------------------------------------------------
// each pixel steps through accept, square, root start, the 16-step serial square root and accumulate
// unless the magnitude sum is zero, the last pixel of a frame then adds two 44-step divides,
// a store read and one more square root before done pulses
// a new pixel may be started once busy is low; results cannot be stalled
// reset clears the controller, positions and sums and sets the configuration registers to defaults;
// the flow store and the result registers are not cleared
module flow_weighted_centroid import fwc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_wdata,
	input  logic               start,
	output logic               busy,
	input  logic signed [15:0] flow_x,
	input  logic signed [15:0] flow_y,
	output logic               done,
	output logic [14:0]        center_x,
	output logic [13:0]        center_y,
	output logic [15:0]        center_magnitude,
	output logic [13:0]        moving_pixels,
	output logic               flow_valid
);

	cmd_t    cmd;
	status_t status;

	fwc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	fwc_datapath u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_wdata        (cfg_wdata),
		.flow_x           (flow_x),
		.flow_y           (flow_y),
		.cmd              (cmd),
		.status           (status),
		.center_x         (center_x),
		.center_y         (center_y),
		.center_magnitude (center_magnitude),
		.moving_pixels    (moving_pixels),
		.flow_valid       (flow_valid)
	);

endmodule
